### rtl/core/r2q_pkg.sv
// ----------------------------------------------------------------------------
// r2q_pkg
// Shared types and constants for the rotation matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
package r2q_pkg;

   localparam int ELEM_W = 16;
   localparam int Q_W    = 16;

   typedef enum logic [1:0] {
      CASE_TRACE = 2'd0,
      CASE_R00   = 2'd1,
      CASE_R11   = 2'd2,
      CASE_R22   = 2'd3
   } pivot_case_type;

   // Control word that travels beside the data through the pipeline.
   typedef struct packed {
      logic           valid;
      pivot_case_type pcase;
      logic           degen;
   } ctl_type;

endpackage

### rtl/core/r2q_sqrt.sv
// ----------------------------------------------------------------------------
// r2q_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module r2q_sqrt #(
   parameter int IN_W  = 32,
   parameter int RES_W = 16,
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              enable,
   input  logic [IN_W-1:0]   arg,
   input  logic [SIDE_W-1:0] side_in,
   output logic [RES_W-1:0]  root,
   output logic [SIDE_W-1:0] side_out
);

   localparam int AW = 2 * RES_W;

   logic [AW-1:0]     rem_ff  [1:RES_W];
   logic [AW-1:0]     val_ff  [1:RES_W];
   logic [RES_W-1:0]  res_ff  [1:RES_W];
   logic [SIDE_W-1:0] side_ff [1:RES_W];

   // Stage k decides result bit RES_W-1-k by restoring subtraction.
   for (genvar k = 0; k < RES_W; k++) begin : g_stage
      logic [AW-1:0]     rem_prev;
      logic [AW-1:0]     val_prev;
      logic [RES_W-1:0]  res_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [AW-1:0]     rem_in;
      logic [AW-1:0]     trial;
      logic [RES_W-1:0]  res_in;
      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign val_prev  = AW'(arg);
         assign res_prev  = '0;
         assign side_prev = side_in;
      end else begin : g_next
         assign rem_prev  = rem_ff[k];
         assign val_prev  = val_ff[k];
         assign res_prev  = res_ff[k];
         assign side_prev = side_ff[k];
      end
      always_comb begin
         rem_in = {rem_prev[AW-3:0], val_prev[AW-1:AW-2]};
         trial  = AW'({res_prev, 2'b01});
         res_in = {res_prev[RES_W-2:0], 1'b0};
         if (rem_in >= trial) begin
            rem_in = rem_in - trial;
            res_in[0] = 1'b1;
         end
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k+1]  <= rem_in;
            val_ff[k+1]  <= {val_prev[AW-3:0], 2'b00};
            res_ff[k+1]  <= res_in;
            side_ff[k+1] <= side_prev;
         end
      end
   end

   assign root     = res_ff[RES_W];
   assign side_out = side_ff[RES_W];

endmodule

### rtl/core/r2q_div.sv
// ----------------------------------------------------------------------------
// r2q_div
// Pipelined signed divider, one quotient bit per stage, truncating toward
// zero, saturating to 16 bits. Zero divisor: sign limit, or 0 for num 0.
// ----------------------------------------------------------------------------
module r2q_div #(
   parameter int NUM_W = 32,
   parameter int DEN_W = 20
) (
   input  logic                    clock,
   input  logic                    enable,
   input  logic signed [NUM_W-1:0] num,
   input  logic        [DEN_W-1:0] den,
   output logic signed [15:0]      quo
);

   logic [NUM_W-1:0] rem_ff [1:NUM_W];
   logic [NUM_W-1:0] mag_ff [1:NUM_W];
   logic [NUM_W-1:0] q_ff   [1:NUM_W];
   logic [DEN_W-1:0] den_ff [1:NUM_W];
   logic             neg_ff [1:NUM_W];
   logic             nz_ff  [1:NUM_W];

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic [NUM_W-1:0] rem_prev;
      logic [NUM_W-1:0] mag_prev;
      logic [NUM_W-1:0] q_prev;
      logic [DEN_W-1:0] den_prev;
      logic             neg_prev;
      logic             nz_prev;
      logic [NUM_W:0]   part;
      logic [NUM_W-1:0] rem_in;
      logic [NUM_W-1:0] q_in;
      if (k == 0) begin : g_first
         assign rem_prev = '0;
         assign mag_prev = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
         assign q_prev   = '0;
         assign den_prev = den;
         assign neg_prev = num[NUM_W-1];
         assign nz_prev  = (num != '0);
      end else begin : g_next
         assign rem_prev = rem_ff[k];
         assign mag_prev = mag_ff[k];
         assign q_prev   = q_ff[k];
         assign den_prev = den_ff[k];
         assign neg_prev = neg_ff[k];
         assign nz_prev  = nz_ff[k];
      end
      always_comb begin
         part   = {rem_prev, mag_prev[NUM_W-1]};
         q_in   = {q_prev[NUM_W-2:0], 1'b0};
         rem_in = part[NUM_W-1:0];
         if (den_prev != '0 && part >= (NUM_W+1)'(den_prev)) begin
            rem_in  = NUM_W'(part - (NUM_W+1)'(den_prev));
            q_in[0] = 1'b1;
         end
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k+1] <= rem_in;
            mag_ff[k+1] <= {mag_prev[NUM_W-2:0], 1'b0};
            q_ff[k+1]   <= q_in;
            den_ff[k+1] <= den_prev;
            neg_ff[k+1] <= neg_prev;
            nz_ff[k+1]  <= nz_prev;
         end
      end
   end

   always_comb begin
      if (den_ff[NUM_W] == '0) begin
         if (!nz_ff[NUM_W])      quo = 16'sd0;
         else if (neg_ff[NUM_W]) quo = -16'sd32768;
         else                    quo = 16'sd32767;
      end else if (neg_ff[NUM_W]) begin
         quo = (q_ff[NUM_W] > NUM_W'(32768)) ? -16'sd32768 : 16'(-q_ff[NUM_W]);
      end else begin
         quo = (q_ff[NUM_W] > NUM_W'(32767)) ? 16'sd32767 : 16'(q_ff[NUM_W]);
      end
   end

endmodule

### rtl/core/rotation_matrix_to_quaternion.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Spurrier conversion of a fixed-point rotation matrix to a quaternion.
// ----------------------------------------------------------------------------
// Pipeline: 2 input and pivot registers, (A4_W + FRAC_BITS + 1)/2 root stages,
// (FRAC_BITS + 18) divide stages and 1 output register.
// Throughput: one item per cycle; the root and divide chains are fully
// pipelined, one bit per stage, and the whole pipe stalls together.
// Reset clears all valid bits; data registers are not reset.
module rotation_matrix_to_quaternion #(
   parameter int FRAC_BITS = 14
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // r00, r01, r02, r10, r11, r12, r20, r21, r22 (16 bits each) from bit 0
   input  logic [143:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // qw, qx, qy, qz (16 bits each), pivot_case (2), degenerate (1), zero fill
   output logic [71:0]  rsp_tdata
);

   localparam int A4_W   = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 3;
   localparam int ARG_W  = A4_W + FRAC_BITS;
   localparam int RES_W  = (ARG_W + 1) / 2;
   localparam int DEN_W  = RES_W + 2;
   localparam int NUM_W  = 18 + FRAC_BITS;
   localparam int SIDE_W = 3 * NUM_W + 3;
   localparam int DLAT   = NUM_W;

   // Whole pipe advances when the output register can take an item.
   logic enable;
   assign enable     = !rsp_tvalid || rsp_tready;
   assign req_tready = enable;

   // Stage 1: register the input.
   logic signed [15:0] r_ff [9];
   logic               v1_ff;
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (enable) v1_ff <= req_tvalid;
   end
   for (genvar i = 0; i < 9; i++) begin : g_in
      always_ff @(posedge clock) begin
         if (enable) r_ff[i] <= req_tdata[16*i +: 16];
      end
   end

   // Stage 2: pick the pivot, form root argument and numerators.
   logic signed [17:0]     tr;
   r2q_pkg::pivot_case_type pc;
   logic signed [A4_W-1:0] a4;
   logic signed [17:0]     n0, n1, n2;
   always_comb begin
      tr = 18'(r_ff[0]) + 18'(r_ff[4]) + 18'(r_ff[8]);
      pc = r2q_pkg::CASE_TRACE;
      if (18'(r_ff[0]) > tr) pc = r2q_pkg::CASE_R00;
      if (r_ff[4] > ((pc == r2q_pkg::CASE_TRACE) ? tr : 18'(r_ff[0])))
         pc = r2q_pkg::CASE_R11;
      if (18'(r_ff[8]) > ((pc == r2q_pkg::CASE_TRACE) ? tr :
                          (pc == r2q_pkg::CASE_R00) ? 18'(r_ff[0]) : 18'(r_ff[4])))
         pc = r2q_pkg::CASE_R22;
      unique case (pc)
         r2q_pkg::CASE_TRACE: begin
            a4 = A4_W'(tr) + (A4_W'(1) << FRAC_BITS);
            n0 = 18'(r_ff[7]) - 18'(r_ff[5]);
            n1 = 18'(r_ff[2]) - 18'(r_ff[6]);
            n2 = 18'(r_ff[3]) - 18'(r_ff[1]);
         end
         r2q_pkg::CASE_R00: begin
            a4 = (A4_W'(r_ff[0]) <<< 1) + (A4_W'(1) << FRAC_BITS) - A4_W'(tr);
            n0 = 18'(r_ff[7]) - 18'(r_ff[5]);
            n1 = 18'(r_ff[3]) + 18'(r_ff[1]);
            n2 = 18'(r_ff[6]) + 18'(r_ff[2]);
         end
         r2q_pkg::CASE_R11: begin
            a4 = (A4_W'(r_ff[4]) <<< 1) + (A4_W'(1) << FRAC_BITS) - A4_W'(tr);
            n0 = 18'(r_ff[2]) - 18'(r_ff[6]);
            n1 = 18'(r_ff[1]) + 18'(r_ff[3]);
            n2 = 18'(r_ff[7]) + 18'(r_ff[5]);
         end
         default: begin
            a4 = (A4_W'(r_ff[8]) <<< 1) + (A4_W'(1) << FRAC_BITS) - A4_W'(tr);
            n0 = 18'(r_ff[3]) - 18'(r_ff[1]);
            n1 = 18'(r_ff[2]) + 18'(r_ff[6]);
            n2 = 18'(r_ff[5]) + 18'(r_ff[7]);
         end
      endcase
   end

   logic [ARG_W-1:0]       arg_ff;
   logic signed [17:0]     n_ff [3];
   r2q_pkg::ctl_type       c2_ff;
   always_ff @(posedge clock) begin
      if (reset) c2_ff.valid <= 1'b0;
      else if (enable) c2_ff.valid <= v1_ff;
      if (enable) begin
         c2_ff.pcase <= pc;
         c2_ff.degen <= a4[A4_W-1];
         arg_ff <= a4[A4_W-1] ? '0 : (ARG_W'(a4) << (FRAC_BITS - 2));
         n_ff[0] <= n0;
         n_ff[1] <= n1;
         n_ff[2] <= n2;
      end
   end

   // Root stages; numerators pre-shifted by FRAC_BITS ride along with case and flag.
   logic [SIDE_W-1:0] side_in, side_out;
   logic [RES_W-1:0]  root;
   assign side_in = {NUM_W'(n_ff[2]) << FRAC_BITS, NUM_W'(n_ff[1]) << FRAC_BITS,
                     NUM_W'(n_ff[0]) << FRAC_BITS, c2_ff.pcase, c2_ff.degen};

   r2q_sqrt #(.IN_W(ARG_W), .RES_W(RES_W), .SIDE_W(SIDE_W)) u_sqrt (
      .clock    (clock),
      .enable   (enable),
      .arg      (arg_ff),
      .side_in  (side_in),
      .root     (root),
      .side_out (side_out)
   );

   logic [RES_W-1:0] vs_ff;
   always_ff @(posedge clock) begin
      if (reset) vs_ff <= '0;
      else if (enable) vs_ff <= {vs_ff[RES_W-2:0], c2_ff.valid};
   end

   // Divide stages; pivot, case and flag ride in a matching delay line.
   logic [DEN_W-1:0]     den;
   logic signed [15:0]   quo [3];
   assign den = {root, 2'b00};
   for (genvar i = 0; i < 3; i++) begin : g_div
      r2q_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
         .clock  (clock),
         .enable (enable),
         .num    (side_out[3 + NUM_W*i +: NUM_W]),
         .den    (den),
         .quo    (quo[i])
      );
   end

   logic [RES_W-1:0]        pv_head;
   r2q_pkg::ctl_type        c_head;
   always_comb begin
      pv_head      = root;
      c_head.valid = vs_ff[RES_W-1];
      c_head.pcase = r2q_pkg::pivot_case_type'(side_out[2:1]);
      c_head.degen = side_out[0] || (root == '0);
   end

   logic [RES_W-1:0]        pv_ff [1:DLAT];
   r2q_pkg::ctl_type        cd_ff [1:DLAT];
   for (genvar k = 1; k <= DLAT; k++) begin : g_dly
      logic [RES_W-1:0] pv_prev;
      r2q_pkg::ctl_type c_prev;
      if (k == 1) begin : g_first
         assign pv_prev = pv_head;
         assign c_prev  = c_head;
      end else begin : g_next
         assign pv_prev = pv_ff[k-1];
         assign c_prev  = cd_ff[k-1];
      end
      always_ff @(posedge clock) begin
         if (reset) cd_ff[k].valid <= 1'b0;
         else if (enable) cd_ff[k].valid <= c_prev.valid;
         if (enable) begin
            pv_ff[k]       <= pv_prev;
            cd_ff[k].pcase <= c_prev.pcase;
            cd_ff[k].degen <= c_prev.degen;
         end
      end
   end

   // Output register: place the pivot per case.
   logic signed [15:0] pv_sat;
   logic signed [15:0] q_in [4];
   assign pv_sat = (pv_ff[DLAT] > RES_W'(32767)) ? 16'sd32767 : 16'(pv_ff[DLAT]);
   always_comb begin
      unique case (cd_ff[DLAT].pcase)
         r2q_pkg::CASE_TRACE: begin
            q_in[0] = pv_sat; q_in[1] = quo[0]; q_in[2] = quo[1]; q_in[3] = quo[2];
         end
         r2q_pkg::CASE_R00: begin
            q_in[0] = quo[0]; q_in[1] = pv_sat; q_in[2] = quo[1]; q_in[3] = quo[2];
         end
         r2q_pkg::CASE_R11: begin
            q_in[0] = quo[0]; q_in[1] = quo[1]; q_in[2] = pv_sat; q_in[3] = quo[2];
         end
         default: begin
            q_in[0] = quo[0]; q_in[1] = quo[1]; q_in[2] = quo[2]; q_in[3] = pv_sat;
         end
      endcase
   end

   logic [71:0] data_ff;
   logic        vo_ff;
   always_ff @(posedge clock) begin
      if (reset) vo_ff <= 1'b0;
      else if (enable) vo_ff <= cd_ff[DLAT].valid;
      if (enable)
         data_ff <= {5'b0, cd_ff[DLAT].degen, cd_ff[DLAT].pcase,
                     q_in[3], q_in[2], q_in[1], q_in[0]};
   end
   assign rsp_tvalid = vo_ff;
   assign rsp_tdata  = data_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("input ready does not follow output stall");
   a_zero_root: assert property (@(posedge clock) disable iff (reset)
      enable && cd_ff[DLAT].valid && pv_ff[DLAT] == '0 |=> rsp_tdata[66])
      else $error("zero pivot without degenerate flag");

endmodule
